// ===== hdl/rth_pkg.sv =====
// ----------------------------------------------------------------------------
// rth_pkg
// shared types and constants of the rgb to hsv converter
// ----------------------------------------------------------------------------
package rth_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int CHAN_W        = 8;
    localparam int DIV_W         = 11;
    localparam int NUM_LANES     = 3;

    localparam int LANE_HUE = 0;
    localparam int LANE_SAT = 1;
    localparam int LANE_VAL = 2;

    localparam logic [DIV_W-1:0] VAL_DIVISOR = DIV_W'(255);

    typedef struct packed {
        logic [DIV_W-1:0] rem;
        logic [DIV_W-1:0] div;
    } t_lane;

    typedef struct packed {
        logic hue_zero;
        logic sat_zero;
    } t_flags;

endpackage

// ===== hdl/rgb_to_hsv_converter.sv =====
// ----------------------------------------------------------------------------
// a transaction passes the rth_front register, then one divider cell register per quotient bit, to o_valid
// throughput: one transaction per cycle while busy is low, set by one division cell per bit
// busy is high during reset and for one cycle after it, and low otherwise
// reset clears the pipeline valid bits, results are not held for a receiver
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter
// pixel rgb to hsv conversion through a chain of divider cells
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter #(
    parameter int FRAC_BITS = rth_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [rth_pkg::CHAN_W-1:0]    i_red,
    input  logic [rth_pkg::CHAN_W-1:0]    i_green,
    input  logic [rth_pkg::CHAN_W-1:0]    i_blue,
    output logic                          o_valid,
    output logic [FRAC_BITS-1:0]          o_hue_frac,
    output logic [FRAC_BITS:0]            o_saturation,
    output logic [FRAC_BITS:0]            o_brightness
);
    import rth_pkg::*;

    localparam int QW      = FRAC_BITS + 1;
    localparam int NCELLS  = FRAC_BITS + 1;
    localparam int LATENCY = FRAC_BITS + 2;

    logic                              r_busy;
    logic                              accept;

    logic [NCELLS:0]                   c_valid;
    t_lane [NCELLS:0][NUM_LANES-1:0]   c_lane;
    logic [NCELLS:0][NUM_LANES-1:0][QW-1:0] c_quot;
    t_flags [NCELLS:0]                 c_flags;
    logic [NUM_LANES-1:0]              front_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    assign busy   = r_busy;
    assign accept = start && !r_busy;

    rth_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_red   (i_red),
        .i_green (i_green),
        .i_blue  (i_blue),
        .o_valid (c_valid[0]),
        .o_lane  (c_lane[0]),
        .o_bit   (front_bit),
        .o_flags (c_flags[0])
    );

    assign c_quot[0] = '0;

    for (genvar i = 0; i < NCELLS; i++) begin : g_cell
        logic [NUM_LANES-1:0] shift_in;
        assign shift_in = (i == 0) ? front_bit : '0;

        rth_div_cell #(
            .QW (QW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (c_valid[i]),
            .i_lane  (c_lane[i]),
            .i_bit   (shift_in),
            .i_quot  (c_quot[i]),
            .i_flags (c_flags[i]),
            .o_valid (c_valid[i+1]),
            .o_lane  (c_lane[i+1]),
            .o_quot  (c_quot[i+1]),
            .o_flags (c_flags[i+1])
        );
    end

    assign o_valid      = c_valid[NCELLS];
    assign o_hue_frac   = c_flags[NCELLS].hue_zero ? '0
                        : c_quot[NCELLS][LANE_HUE][FRAC_BITS-1:0];
    assign o_saturation = c_flags[NCELLS].sat_zero ? '0
                        : c_quot[NCELLS][LANE_SAT];
    assign o_brightness = c_quot[NCELLS][LANE_VAL];

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##LATENCY o_valid)
        else $error("result strobe missing after transaction");

    a_sat_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_saturation <= (QW'(1) << FRAC_BITS)))
        else $error("saturation above one");

    a_val_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_brightness <= (QW'(1) << FRAC_BITS)))
        else $error("brightness above one");

    a_gray_hue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_saturation == '0)) |-> (o_hue_frac == '0))
        else $error("hue nonzero for gray pixel");

endmodule

// ===== hdl/rth_front.sv =====
// ----------------------------------------------------------------------------
// rth_front
// max, min and hue numerator of one pixel, loads the divider lanes
// ----------------------------------------------------------------------------
module rth_front (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    input  logic [rth_pkg::CHAN_W-1:0]           i_red,
    input  logic [rth_pkg::CHAN_W-1:0]           i_green,
    input  logic [rth_pkg::CHAN_W-1:0]           i_blue,
    output logic                                 o_valid,
    output rth_pkg::t_lane [rth_pkg::NUM_LANES-1:0] o_lane,
    output logic [rth_pkg::NUM_LANES-1:0]        o_bit,
    output rth_pkg::t_flags                      o_flags
);
    import rth_pkg::*;

    logic                   r_valid;
    t_lane [NUM_LANES-1:0]  r_lane;
    logic [NUM_LANES-1:0]   r_bit;
    t_flags                 r_flags;

    t_lane [NUM_LANES-1:0]  n_lane;
    logic [NUM_LANES-1:0]   n_bit;
    t_flags                 n_flags;

    logic                   red_hi;
    logic                   green_hi;
    logic [CHAN_W-1:0]      hi;
    logic [CHAN_W-1:0]      lo;
    logic [CHAN_W-1:0]      rng;
    logic [DIV_W-1:0]       rng6;
    logic [DIV_W-1:0]       num;

    always_comb begin
        red_hi   = (i_red >= i_green) && (i_red >= i_blue);
        green_hi = (i_green >= i_blue);
        if (red_hi) begin
            hi = i_red;
        end else if (green_hi) begin
            hi = i_green;
        end else begin
            hi = i_blue;
        end
        if ((i_red <= i_green) && (i_red <= i_blue)) begin
            lo = i_red;
        end else if (i_green <= i_blue) begin
            lo = i_green;
        end else begin
            lo = i_blue;
        end
        rng  = hi - lo;
        rng6 = {1'b0, rng, 2'b00} + {2'b00, rng, 1'b0};
        if (red_hi) begin
            if (i_green >= i_blue) begin
                num = DIV_W'(i_green) - DIV_W'(i_blue);
            end else begin
                num = rng6 - (DIV_W'(i_blue) - DIV_W'(i_green));
            end
        end else if (green_hi) begin
            num = {2'b00, rng, 1'b0} + DIV_W'(i_blue) - DIV_W'(i_red);
        end else begin
            num = {1'b0, rng, 2'b00} + DIV_W'(i_red) - DIV_W'(i_green);
        end

        n_lane[LANE_HUE].rem = {1'b0, num[DIV_W-1:1]};
        n_lane[LANE_HUE].div = rng6;
        n_bit[LANE_HUE]      = num[0];
        n_lane[LANE_SAT].rem = {4'b0000, rng[CHAN_W-1:1]};
        n_lane[LANE_SAT].div = DIV_W'(hi);
        n_bit[LANE_SAT]      = rng[0];
        n_lane[LANE_VAL].rem = {4'b0000, hi[CHAN_W-1:1]};
        n_lane[LANE_VAL].div = VAL_DIVISOR;
        n_bit[LANE_VAL]      = hi[0];
        n_flags.hue_zero     = (rng == '0);
        n_flags.sat_zero     = (hi == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lane  <= n_lane;
        r_bit   <= n_bit;
        r_flags <= n_flags;
    end

    assign o_valid = r_valid;
    assign o_lane  = r_lane;
    assign o_bit   = r_bit;
    assign o_flags = r_flags;

endmodule

// ===== hdl/rth_div_cell.sv =====
// ----------------------------------------------------------------------------
// rth_div_cell
// one restoring division step for the hue, saturation and value lanes
// ----------------------------------------------------------------------------
module rth_div_cell #(
    parameter int QW = rth_pkg::FRAC_BITS_DEF + 1
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_valid,
    input  rth_pkg::t_lane [rth_pkg::NUM_LANES-1:0] i_lane,
    input  logic [rth_pkg::NUM_LANES-1:0]           i_bit,
    input  logic [rth_pkg::NUM_LANES-1:0][QW-1:0]   i_quot,
    input  rth_pkg::t_flags                         i_flags,
    output logic                                    o_valid,
    output rth_pkg::t_lane [rth_pkg::NUM_LANES-1:0] o_lane,
    output logic [rth_pkg::NUM_LANES-1:0][QW-1:0]   o_quot,
    output rth_pkg::t_flags                         o_flags
);
    import rth_pkg::*;

    logic                              r_valid;
    t_lane [NUM_LANES-1:0]             r_lane;
    logic [NUM_LANES-1:0][QW-1:0]      r_quot;
    t_flags                            r_flags;

    t_lane [NUM_LANES-1:0]             n_lane;
    logic [NUM_LANES-1:0][QW-1:0]      n_quot;

    logic [NUM_LANES-1:0][DIV_W:0]     trial;
    logic [NUM_LANES-1:0]              fits;

    always_comb begin
        for (int k = 0; k < NUM_LANES; k++) begin
            trial[k]      = {i_lane[k].rem, i_bit[k]};
            fits[k]       = (trial[k] >= {1'b0, i_lane[k].div});
            n_lane[k].div = i_lane[k].div;
            if (fits[k]) begin
                n_lane[k].rem = DIV_W'(trial[k] - {1'b0, i_lane[k].div});
            end else begin
                n_lane[k].rem = trial[k][DIV_W-1:0];
            end
            n_quot[k] = {i_quot[k][QW-2:0], fits[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lane  <= n_lane;
        r_quot  <= n_quot;
        r_flags <= i_flags;
    end

    assign o_valid = r_valid;
    assign o_lane  = r_lane;
    assign o_quot  = r_quot;
    assign o_flags = r_flags;

endmodule
